FILE: rtl/hgs_pkg.sv
// Shared types and constants for the HTTP GET request screener.
// No dependencies; imported by every module of the block but hgs_queue.
`default_nettype none

package hgs_pkg;

    localparam int DEF_MAX_PATH_LEN = 4096;
    localparam int DEF_QUEUE_DEPTH  = 2;
    localparam int CFG_W            = 16;
    localparam logic [CFG_W-1:0] MAX_REQ_RESET = 16'd2744;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_T     = 8'h54;

    // extension bytes, first byte in the low lane
    localparam logic [31:0] EXT_JPG  = 32'h0067706A;
    localparam logic [31:0] EXT_HTML = 32'h6C6D7468;
    localparam logic [31:0] EXT_CSS  = 32'h00737363;
    localparam logic [31:0] EXT_JS   = 32'h0000736A;

    // extension count: 0 none, k+1 for k bytes, EXT_LONG past four
    localparam logic [2:0] EXT_NONE   = 3'd0;
    localparam logic [2:0] EXT_DOT    = 3'd1;
    localparam logic [2:0] EXT_2BYTES = 3'd3;
    localparam logic [2:0] EXT_3BYTES = 3'd4;
    localparam logic [2:0] EXT_4BYTES = 3'd5;
    localparam logic [2:0] EXT_LONG   = 3'd6;

    typedef enum logic [1:0] {
        VD_SERVE   = 2'd0,
        VD_ESCAPE  = 2'd1,
        VD_NOT_GET = 2'd2,
        VD_NO_TERM = 2'd3
    } t_verdict;

    typedef enum logic [2:0] {
        CT_JPEG  = 3'd0,
        CT_HTML  = 3'd1,
        CT_CSS   = 3'd2,
        CT_JS    = 3'd3,
        CT_OCTET = 3'd4
    } t_ctype;

    typedef struct packed {
        t_verdict    verdict;
        logic [2:0]  ext_cnt;
        logic [31:0] ext_bytes;
    } t_fin;

endpackage

`default_nettype wire

FILE: rtl/hgs_front.sv
// Front end: takes request bytes, runs the parser and raises one finish record per request.
// Depends on hgs_pkg.
`default_nettype none

module hgs_front #(
    parameter int MAX_PATH_LEN = hgs_pkg::DEF_MAX_PATH_LEN
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [hgs_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  wire logic                               i_push,
    input  wire logic                               i_q_full,
    input  wire logic [7:0]                         i_data_byte,
    input  wire logic                               i_new_request,
    output logic                                    o_q_wr,
    output hgs_pkg::t_fin                           o_fin,
    output logic [$clog2(MAX_PATH_LEN+1)-1:0]       o_path
);
    import hgs_pkg::*;

    localparam int PATH_W = $clog2(MAX_PATH_LEN + 1);
    localparam logic [PATH_W-1:0] PCNT_SAT = PATH_W'(MAX_PATH_LEN);
    localparam logic [2:0] MM_DONE = 3'd3;
    localparam logic [2:0] MM_FAIL = 3'd4;
    localparam logic [11:0] DEPTH_MAX = 12'd4095;

    typedef enum logic [1:0] {
        PH_METHOD = 2'd0,
        PH_PATH   = 2'd1,
        PH_REST   = 2'd2
    } t_phase;

    logic [CFG_W-1:0]  r_max_req;
    t_phase            r_phase, c_phase, n_phase;
    logic [2:0]        r_mm, c_mm, n_mm;
    logic [1:0]        r_term, c_term, n_term;
    logic [15:0]       r_bytes, c_bytes, n_bytes;
    logic [11:0]       r_depth, c_depth, n_depth;
    logic              r_esc, c_esc, n_esc;
    logic [15:0]       r_prior, c_prior, n_prior;
    logic [PATH_W-1:0] r_pcnt, c_pcnt, n_pcnt;
    logic [31:0]       r_ext, c_ext, n_ext;
    logic [2:0]        r_ecnt, c_ecnt, n_ecnt;
    logic              r_sent, c_sent, n_sent;

    logic       accept, done, fin;
    logic [7:0] exp_char;
    logic [1:0] lane;
    t_verdict   verdict;

    assign accept = i_push && !i_q_full;

    always_comb begin
        unique case (c_mm[1:0])
            2'd0:    exp_char = CH_G;
            2'd1:    exp_char = CH_E;
            default: exp_char = CH_T;
        endcase
    end

    always_comb begin
        c_phase = i_new_request ? PH_METHOD : r_phase;
        c_mm    = i_new_request ? 3'd0 : r_mm;
        c_term  = i_new_request ? 2'd0 : r_term;
        c_bytes = i_new_request ? 16'd0 : r_bytes;
        c_depth = i_new_request ? 12'd0 : r_depth;
        c_esc   = i_new_request ? 1'b0 : r_esc;
        c_prior = i_new_request ? 16'd0 : r_prior;
        c_pcnt  = i_new_request ? '0 : r_pcnt;
        c_ext   = i_new_request ? 32'd0 : r_ext;
        c_ecnt  = i_new_request ? EXT_NONE : r_ecnt;
        c_sent  = i_new_request ? 1'b0 : r_sent;

        n_phase = c_phase;
        n_mm    = c_mm;
        n_term  = c_term;
        n_bytes = c_bytes;
        n_depth = c_depth;
        n_esc   = c_esc;
        n_prior = c_prior;
        n_pcnt  = c_pcnt;
        n_ext   = c_ext;
        n_ecnt  = c_ecnt;
        n_sent  = c_sent;
        done    = 1'b0;
        fin     = 1'b0;
        lane    = 2'(c_ecnt - 3'd1);

        if (!c_sent) begin
            if (c_bytes != 16'hFFFF) begin
                n_bytes = c_bytes + 16'd1;
            end

            if (i_data_byte == CH_CR) begin
                n_term = (c_term == 2'd2) ? 2'd3 : 2'd1;
            end else if (i_data_byte == CH_LF) begin
                if (c_term == 2'd1) begin
                    n_term = 2'd2;
                end else if (c_term == 2'd3) begin
                    done = 1'b1;
                end else begin
                    n_term = 2'd0;
                end
            end else begin
                n_term = 2'd0;
            end

            unique case (c_phase)
                PH_METHOD: begin
                    if (i_data_byte == CH_SPACE) begin
                        if (c_mm == MM_DONE) begin
                            n_phase = PH_PATH;
                        end else begin
                            n_mm    = MM_FAIL;
                            n_phase = PH_REST;
                        end
                    end else if (c_mm < MM_DONE && i_data_byte == exp_char) begin
                        n_mm = c_mm + 3'd1;
                    end else begin
                        n_mm = MM_FAIL;
                    end
                end
                PH_PATH: begin
                    if (i_data_byte == CH_SPACE) begin
                        n_phase = PH_REST;
                    end else begin
                        if (c_pcnt >= PCNT_SAT) begin
                            n_esc = 1'b1;
                        end
                        if (c_pcnt >= PATH_W'(2) && i_data_byte == CH_SLASH) begin
                            if (c_prior == {CH_DOT, CH_DOT}) begin
                                if (c_depth == 12'd0) begin
                                    n_esc = 1'b1;
                                end else begin
                                    n_depth = c_depth - 12'd1;
                                end
                            end else if (c_depth < DEPTH_MAX) begin
                                n_depth = c_depth + 12'd1;
                            end
                        end
                        if (i_data_byte == CH_SLASH) begin
                            n_ecnt = EXT_NONE;
                            n_ext  = 32'd0;
                        end else if (i_data_byte == CH_DOT) begin
                            n_ecnt = EXT_DOT;
                            n_ext  = 32'd0;
                        end else if (c_ecnt >= EXT_DOT && c_ecnt <= EXT_3BYTES) begin
                            n_ext[{lane, 3'b000} +: 8] = i_data_byte;
                            n_ecnt = c_ecnt + 3'd1;
                        end else if (c_ecnt == EXT_4BYTES) begin
                            n_ecnt = EXT_LONG;
                        end
                        if (c_pcnt < PCNT_SAT) begin
                            n_pcnt = c_pcnt + PATH_W'(1);
                        end
                        n_prior = {c_prior[7:0], i_data_byte};
                    end
                end
                default: begin
                end
            endcase

            fin    = done || (n_bytes >= r_max_req);
            n_sent = fin;
        end
    end

    always_comb begin
        if (!done) begin
            verdict = VD_NO_TERM;
        end else if (n_phase == PH_METHOD || n_mm != MM_DONE) begin
            verdict = VD_NOT_GET;
        end else if (n_esc) begin
            verdict = VD_ESCAPE;
        end else begin
            verdict = VD_SERVE;
        end
    end

    assign o_q_wr          = accept && fin;
    assign o_fin.verdict   = verdict;
    assign o_fin.ext_cnt   = n_ecnt;
    assign o_fin.ext_bytes = n_ext;
    assign o_path          = n_pcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_req <= MAX_REQ_RESET;
            r_phase   <= PH_METHOD;
            r_mm      <= 3'd0;
            r_term    <= 2'd0;
            r_bytes   <= 16'd0;
            r_depth   <= 12'd0;
            r_esc     <= 1'b0;
            r_prior   <= 16'd0;
            r_pcnt    <= '0;
            r_ext     <= 32'd0;
            r_ecnt    <= EXT_NONE;
            r_sent    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_req <= i_cfg_wdata;
            end
            if (accept) begin
                r_phase <= n_phase;
                r_mm    <= n_mm;
                r_term  <= n_term;
                r_bytes <= n_bytes;
                r_depth <= n_depth;
                r_esc   <= n_esc;
                r_prior <= n_prior;
                r_pcnt  <= n_pcnt;
                r_ext   <= n_ext;
                r_ecnt  <= n_ecnt;
                r_sent  <= n_sent;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hgs_queue.sv
// Short register queue between the parser front end and the result back end.
// No package dependencies.
`default_nettype none

module hgs_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic                   o_full,
    input  wire logic              i_rd,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_rdata
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, r_rptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              wr_en, rd_en;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hgs_back.sv
// Back end: classifies the extension, formats the result and holds it in the output register.
// Depends on hgs_pkg.
`default_nettype none

module hgs_back #(
    parameter int PATH_W = 13
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire hgs_pkg::t_fin     i_fin,
    input  wire logic [PATH_W-1:0] i_path,
    output logic                   o_q_rd,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic [1:0]             o_verdict,
    output logic [2:0]             o_content_type,
    output logic [PATH_W-1:0]      o_path_length
);
    import hgs_pkg::*;

    logic              r_valid;
    t_verdict          r_verdict;
    t_ctype            r_ctype;
    logic [PATH_W-1:0] r_plen;
    t_ctype            n_ctype;
    logic [PATH_W-1:0] n_plen;
    logic              load;

    always_comb begin
        priority if (i_fin.verdict != VD_SERVE) begin
            n_ctype = CT_OCTET;
        end else if (i_fin.ext_cnt == EXT_3BYTES && i_fin.ext_bytes == EXT_JPG) begin
            n_ctype = CT_JPEG;
        end else if (i_fin.ext_cnt == EXT_4BYTES && i_fin.ext_bytes == EXT_HTML) begin
            n_ctype = CT_HTML;
        end else if (i_fin.ext_cnt == EXT_3BYTES && i_fin.ext_bytes == EXT_CSS) begin
            n_ctype = CT_CSS;
        end else if (i_fin.ext_cnt == EXT_2BYTES && i_fin.ext_bytes == EXT_JS) begin
            n_ctype = CT_JS;
        end else begin
            n_ctype = CT_OCTET;
        end
    end

    assign n_plen = (i_fin.verdict == VD_SERVE || i_fin.verdict == VD_ESCAPE) ? i_path : '0;
    assign load   = i_q_valid && (!r_valid || i_pop);
    assign o_q_rd = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_verdict <= i_fin.verdict;
            r_ctype   <= n_ctype;
            r_plen    <= n_plen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    assign o_empty        = !r_valid;
    assign o_verdict      = r_verdict;
    assign o_content_type = r_ctype;
    assign o_path_length  = r_plen;

endmodule

`default_nettype wire

FILE: rtl/http_get_request_screener_unit.sv
// A verdict enters the queue with the byte transfer that ends it and moves on to the output
// register when it is empty or popped. Throughput: one byte per cycle while full is low;
// full rises only when two verdicts wait in the queue behind an output register not popped.
// Reset: synchronous, active low; clears the parser, queue and output register, and sets
// max_request_bytes to 2744.
// Top level; depends on hgs_pkg, hgs_front, hgs_queue, hgs_back.
`default_nettype none

module http_get_request_screener_unit #(
    parameter int MAX_PATH_LEN = hgs_pkg::DEF_MAX_PATH_LEN
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [hgs_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_new_request,
    input  wire logic                          pop,
    output logic                               empty,
    output logic [1:0]                         o_verdict,
    output logic [2:0]                         o_content_type,
    output logic [$clog2(MAX_PATH_LEN+1)-1:0]  o_path_length
);
    import hgs_pkg::*;

    localparam int PATH_W = $clog2(MAX_PATH_LEN + 1);
    localparam int Q_W    = $bits(t_fin) + PATH_W;

    logic              q_wr, q_full, q_rd, q_valid;
    t_fin              f_fin, b_fin;
    logic [PATH_W-1:0] f_path, b_path;
    logic [Q_W-1:0]    q_rdata;

    hgs_front #(
        .MAX_PATH_LEN(MAX_PATH_LEN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push       (push),
        .i_q_full     (q_full),
        .i_data_byte  (i_data_byte),
        .i_new_request(i_new_request),
        .o_q_wr       (q_wr),
        .o_fin        (f_fin),
        .o_path       (f_path)
    );

    hgs_queue #(
        .DATA_W(Q_W),
        .DEPTH (DEF_QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (q_wr),
        .i_wdata({f_fin, f_path}),
        .o_full (q_full),
        .i_rd   (q_rd),
        .o_valid(q_valid),
        .o_rdata(q_rdata)
    );

    assign b_fin  = t_fin'(q_rdata[Q_W-1:PATH_W]);
    assign b_path = q_rdata[PATH_W-1:0];
    assign full   = q_full;

    hgs_back #(
        .PATH_W(PATH_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_fin         (b_fin),
        .i_path        (b_path),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_verdict     (o_verdict),
        .o_content_type(o_content_type),
        .o_path_length (o_path_length)
    );

endmodule

`default_nettype wire

FILE: rtl/hgs_checker.sv
// Port-level checks for the screener, bound to the top level.
// Depends on hgs_pkg and http_get_request_screener_unit.
`default_nettype none

module hgs_checker #(
    parameter int PATH_W = 13
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              full,
    input wire logic              empty,
    input wire logic              pop,
    input wire logic [1:0]        o_verdict,
    input wire logic [2:0]        o_content_type,
    input wire logic [PATH_W-1:0] o_path_length
);
    import hgs_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not clear after reset");

    a_ctype_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_content_type <= CT_OCTET))
        else $error("content type out of range");

    a_reject_octet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_verdict != VD_SERVE) |-> (o_content_type == CT_OCTET))
        else $error("rejected request with a content type");

    a_nopath_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_verdict == VD_NOT_GET || o_verdict == VD_NO_TERM))
            |-> (o_path_length == '0))
        else $error("path length on a request without path");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_verdict) && $stable(o_content_type)))
        else $error("waiting result changed");

endmodule

bind http_get_request_screener_unit hgs_checker #(
    .PATH_W(PATH_W)
) u_hgs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_verdict     (o_verdict),
    .o_content_type(o_content_type),
    .o_path_length (o_path_length)
);

`default_nettype wire
